@@ hw/rtl/psri_pkg.sv @@
// shared types and constants for the plane segment and ray intersection block
package psri_pkg;

  // field and register widths
  localparam int FW  = 32;  // coordinate field width
  localparam int SW  = 36;  // signed distance width
  localparam int MW  = 35;  // distance magnitude width
  localparam int DW  = 36;  // divisor width
  localparam int XW  = 33;  // coordinate magnitude width
  localparam int NPW = XW + MW;  // dividend width
  localparam int QB  = 34;  // quotient bits produced by the divider
  localparam int QW  = QB + 1;  // quotient width including the cap value
  localparam int DIV_LAT = QB + 1;  // divider register stages
  localparam int PSW = 37;  // width of the unsaturated point sum

  localparam logic signed [FW-1:0] NORMAL_Z_RESET = 32'sh4000_0000;

  // result codes
  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_AHEAD  = 2'd1,
    HIT_BEHIND = 2'd2,
    HIT_PLANE  = 2'd3
  } hit_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NORMAL_X = 2'd0,
    REG_NORMAL_Y = 2'd1,
    REG_NORMAL_Z = 2'd2,
    REG_OFFSET   = 2'd3
  } reg_idx_t;

  // what travels beside the divider
  typedef struct packed {
    logic             vld;
    hit_t             code;
    logic [2:0]       neg;
    logic [2:0][FW-1:0] base;
  } side_t;

endpackage

@@ hw/rtl/psri_div.sv @@
// pipelined restoring divider with a capped quotient, one quotient bit per stage
module psri_div import psri_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [NPW-1:0] num,
  input  logic [DW-1:0]  den,
  output logic [QW-1:0]  quo
);

  logic [DW-1:0] rem [0:QB];
  logic [QB-1:0] low [0:QB];
  logic [DW-1:0] dq  [0:QB];
  logic [QB-1:0] qq  [0:QB];
  logic          ov  [0:QB];

  logic [NPW+1:0] num_ext;
  logic [NPW+1:0] den_sh;

  // quotient would not fit in QB bits
  assign num_ext = {2'b00, num};
  assign den_sh  = {den, {QB{1'b0}}};

  // entry stage: overflow check and initial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= (num_ext >= den_sh);
      rem[0] <= DW'(num[NPW-1:QB]);
      low[0] <= num[QB-1:0];
      dq[0]  <= den;
      qq[0]  <= '0;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    assign trial = {rem[k], low[k][QB-1]};
    assign ge    = (trial >= {1'b0, dq[k]});
    assign diff  = trial - {1'b0, dq[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[k+1] <= {low[k][QB-2:0], 1'b0};
        qq[k+1]  <= {qq[k][QB-2:0], ge};
        dq[k+1]  <= dq[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  // capped quotient
  assign quo = ov[QB] ? (QW'(1) << QB) : {1'b0, qq[QB]};

endmodule

@@ hw/rtl/plane_segment_ray_intersect.sv @@
// Pipeline: 4 front stages, 35 divider stages and one output stage. Throughput: one
// item per cycle while the output is not stalled, set by the fully pipelined 34-step
// restoring divider on each axis. A stall at the output freezes the whole pipeline.
// Reset (rst, synchronous) clears all valid bits and loads the plane registers with
// normal (0, 0, 1.0) and offset 0.
module plane_segment_ray_intersect import psri_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          action,
  input  logic [FW-1:0] first_x,
  input  logic [FW-1:0] first_y,
  input  logic [FW-1:0] first_z,
  input  logic [FW-1:0] second_x,
  input  logic [FW-1:0] second_y,
  input  logic [FW-1:0] second_z,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    hit_code,
  output logic [FW-1:0] point_x,
  output logic [FW-1:0] point_y,
  output logic [FW-1:0] point_z
);

  localparam int CW = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam int SH = FW - CW;
  localparam logic signed [PSW-1:0] SAT_HI = (PSW'(1) <<< (CW - 1)) - PSW'(1);
  localparam logic signed [PSW-1:0] SAT_LO = -SAT_HI - PSW'(1);

  logic signed [FW-1:0] normal_x, normal_y, normal_z, plane_offset;
  logic en;

  // whole pipeline advances unless the result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= NORMAL_Z_RESET;
      plane_offset <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NORMAL_X: normal_x     <= $signed(cfg_data);
        REG_NORMAL_Y: normal_y     <= $signed(cfg_data);
        REG_NORMAL_Z: normal_z     <= $signed(cfg_data);
        REG_OFFSET:   plane_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sign-extend the coordinates from the active width
  logic [2:0][FW-1:0] fa, fb;
  logic [2:0][FW-1:0] sa, sb;
  logic signed [FW-1:0] nv [3];
  assign fa = {first_z, first_y, first_x};
  assign fb = {second_z, second_y, second_x};
  assign nv[0] = normal_x;
  assign nv[1] = normal_y;
  assign nv[2] = normal_z;

  for (genvar i = 0; i < 3; i++) begin : g_sext
    assign sa[i] = FW'($signed(fa[i] << SH) >>> SH);
    assign sb[i] = FW'($signed(fb[i] << SH) >>> SH);
  end

  // stage 1: normal products
  logic vld1, act1;
  logic [2:0][FW-1:0] a1, b1;
  logic signed [2*FW-1:0] pa1 [3];
  logic signed [2*FW-1:0] pb1 [3];

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else if (en) vld1 <= in_valid;
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        pa1[i] <= nv[i] * $signed(sa[i]);
        pb1[i] <= nv[i] * $signed(sb[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= action;
      a1   <= sa;
      b1   <= sb;
    end
  end

  // stage 2: floored products summed into signed distances
  logic signed [2*FW-1:0] fla [3];
  logic signed [2*FW-1:0] flb [3];
  logic signed [SW-1:0] dota, dotb, off_ext;
  for (genvar i = 0; i < 3; i++) begin : g_floor
    assign fla[i] = pa1[i] >>> 30;
    assign flb[i] = pb1[i] >>> 30;
  end
  assign off_ext = SW'(plane_offset);
  assign dota = $signed(fla[0][SW-1:0]) + $signed(fla[1][SW-1:0]) + $signed(fla[2][SW-1:0]);
  assign dotb = $signed(flb[0][SW-1:0]) + $signed(flb[1][SW-1:0]) + $signed(flb[2][SW-1:0]);

  logic vld2, act2;
  logic [2:0][FW-1:0] a2, b2;
  logic signed [SW-1:0] s1_2, s2_2, dt2;

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else if (en) vld2 <= vld1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      a2   <= a1;
      b2   <= b1;
      s1_2 <= dota + off_ext;
      s2_2 <= dotb + off_ext;
      dt2  <= -dotb;
    end
  end

  // stage 3: classify and pick divider operands
  logic [MW-1:0] m1, m2, mdt;
  logic [DW-1:0] dist_sum;
  logic          same_side;
  hit_t          code_c;
  logic [2:0]    neg_c;
  logic [2:0][XW-1:0] x_c;
  logic [MW-1:0] y_c;
  logic [DW-1:0] den_c;
  logic signed [SW-1:0] ns1, ns2, ndt;
  logic signed [XW-1:0] diff_c [3];

  assign ns1 = -s1_2;
  assign ns2 = -s2_2;
  assign ndt = -dt2;
  assign m1  = s1_2[SW-1] ? ns1[MW-1:0] : s1_2[MW-1:0];
  assign m2  = s2_2[SW-1] ? ns2[MW-1:0] : s2_2[MW-1:0];
  assign mdt = dt2[SW-1]  ? ndt[MW-1:0] : dt2[MW-1:0];
  assign dist_sum = DW'(m1) + DW'(m2);
  assign same_side = ((s1_2 > 0) && (s2_2 > 0)) || ((s1_2 < 0) && (s2_2 < 0));

  for (genvar i = 0; i < 3; i++) begin : g_diff
    assign diff_c[i] = XW'($signed(b2[i])) - XW'($signed(a2[i]));
  end

  always_comb begin
    code_c = HIT_NONE;
    neg_c  = '0;
    x_c    = '0;
    y_c    = '0;
    den_c  = '0;
    if (!act2) begin
      // segment query
      y_c   = m1;
      den_c = dist_sum;
      for (int i = 0; i < 3; i++) begin
        neg_c[i] = diff_c[i][XW-1];
        x_c[i]   = diff_c[i][XW-1] ? XW'(-diff_c[i]) : XW'(diff_c[i]);
      end
      if (same_side) code_c = HIT_NONE;
      else if (dist_sum == '0) code_c = HIT_PLANE;
      else code_c = HIT_AHEAD;
    end else begin
      // ray query
      y_c   = m1;
      den_c = DW'(mdt);
      for (int i = 0; i < 3; i++) begin
        neg_c[i] = (b2[i][FW-1] ^ s1_2[SW-1]) ^ dt2[SW-1];
        x_c[i]   = b2[i][FW-1] ? XW'(-$signed(b2[i])) : XW'(b2[i]);
      end
      if (dt2 == '0) code_c = (s1_2 != '0) ? HIT_NONE : HIT_PLANE;
      else if ((s1_2 != '0) && ((s1_2 > 0) == (dt2 > 0))) code_c = HIT_AHEAD;
      else code_c = HIT_BEHIND;
    end
  end

  logic vld3;
  hit_t code3;
  logic [2:0] neg3;
  logic [2:0][FW-1:0] a3;
  logic [2:0][XW-1:0] x3;
  logic [MW-1:0] y3;
  logic [DW-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) vld3 <= 1'b0;
    else if (en) vld3 <= vld2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code3 <= code_c;
      neg3  <= neg_c;
      a3    <= a2;
      x3    <= x_c;
      y3    <= y_c;
      den3  <= den_c;
    end
  end

  // stage 4: dividends
  side_t side4;
  logic [NPW-1:0] n4 [3];
  logic [DW-1:0]  den4;

  always_ff @(posedge clk) begin
    if (rst) side4.vld <= 1'b0;
    else if (en) side4.vld <= vld3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4.code <= code3;
      side4.neg  <= neg3;
      side4.base <= a3;
      den4       <= den3;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    always_ff @(posedge clk) begin
      if (en) n4[i] <= NPW'(x3[i]) * NPW'(y3);
    end
  end

  // per-axis dividers
  logic [QW-1:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    psri_div u_div (
      .clk (clk),
      .en  (en),
      .num (n4[i]),
      .den (den4),
      .quo (quo[i])
    );
  end

  // sideband delay line matching the divider
  side_t dl [DIV_LAT];
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) dl[k].vld <= 1'b0;
      else if (en) dl[k].vld <= (k == 0) ? side4.vld : dl[(k == 0) ? 0 : k - 1].vld;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dl[k].code <= (k == 0) ? side4.code : dl[(k == 0) ? 0 : k - 1].code;
        dl[k].neg  <= (k == 0) ? side4.neg  : dl[(k == 0) ? 0 : k - 1].neg;
        dl[k].base <= (k == 0) ? side4.base : dl[(k == 0) ? 0 : k - 1].base;
      end
    end
  end

  // final offset, saturation and miss zeroing
  side_t last;
  logic [2:0][FW-1:0] pt_c;
  assign last = dl[DIV_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_pt
    logic signed [PSW-1:0] base_e, q_e, sum;
    logic signed [PSW-1:0] sat;
    assign base_e = PSW'($signed(last.base[i]));
    assign q_e    = $signed(PSW'(quo[i]));
    assign sum    = last.neg[i] ? (base_e - q_e) : (base_e + q_e);
    assign sat    = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);
    always_comb begin
      unique case (last.code)
        HIT_NONE:  pt_c[i] = '0;
        HIT_PLANE: pt_c[i] = last.base[i];
        default:   pt_c[i] = sat[FW-1:0];
      endcase
    end
  end

  // output register
  hit_t out_code;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= last.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_code <= last.code;
      point_x  <= pt_c[0];
      point_y  <= pt_c[1];
      point_z  <= pt_c[2];
    end
  end

  assign hit_code = out_code;

  // checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_code == HIT_NONE)) |->
      ((point_x == '0) && (point_y == '0) && (point_z == '0)))
    else $error("miss result with nonzero point");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld1)
    else $error("accepted item missing from first stage");

endmodule
